>>> sv/udiv64_pkg.sv
// Shared types and constants for the 64-bit unsigned divider.
// No dependencies; used by udiv64_cell and unsigned_divide_64_unit.
package udiv64_pkg;

   localparam int DataWidth = 64;

   typedef logic [DataWidth-1:0] word_type;

   // State carried from one divider cell to the next.
   typedef struct packed {
      logic     valid;
      logic     div_zero;
      word_type rem;
      word_type numq;   // unconsumed dividend bits above, quotient bits below
      word_type den;
   } stage_type;

endpackage

>>> sv/unsigned_divide_64_unit.sv
// Unsigned 64-bit divider top level: a chain of 64 udiv64_cell stages.
// Depends on udiv64_pkg and udiv64_cell.
//
// Usage:
//   Input channel req_valid/req_ready carries req_dividend and req_divisor.
//   Result channel rsp_valid/rsp_ready carries rsp_quotient, rsp_remainder
//   and rsp_divide_by_zero. A zero divisor gives quotient 0, remainder 0
//   and raises rsp_divide_by_zero.
//   Each quotient bit is resolved by its own cell of the chain, so an
//   accepted item reaches rsp_valid after passing through all 64 cells.
//   Throughput: one item per cycle except during a stall; every cell
//   holds a different item. The last cell is the output register.
//   Stall: while rsp_valid is high and rsp_ready low the whole chain holds
//   and req_ready drops; while the output is empty the whole chain moves,
//   empty slots included, so gaps between items are kept, not closed up.
//   Reset: synchronous, active high; clears every cell's valid bit, so the
//   block comes out of reset empty and ready.
module unsigned_divide_64_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [udiv64_pkg::DataWidth-1:0] req_dividend,
   input  logic [udiv64_pkg::DataWidth-1:0] req_divisor,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [udiv64_pkg::DataWidth-1:0] rsp_quotient,
   output logic [udiv64_pkg::DataWidth-1:0] rsp_remainder,
   output logic                       rsp_divide_by_zero
);
   import udiv64_pkg::*;

   stage_type               links [0:DataWidth];
   logic [DataWidth-1:0]    valid_vec;
   logic                    enable;

   assign enable    = !links[DataWidth].valid || rsp_ready;
   assign req_ready = enable;

   always_comb begin
      links[0].valid    = req_valid;
      links[0].div_zero = (req_divisor == '0);
      links[0].rem      = '0;
      links[0].numq     = req_dividend;
      links[0].den      = req_divisor;
   end

   for (genvar i = 0; i < DataWidth; i++) begin : g_cell
      udiv64_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_in  (links[i]),
         .stage_out (links[i+1])
      );
      assign valid_vec[i] = links[i+1].valid;
   end

   assign rsp_valid          = links[DataWidth].valid;
   assign rsp_divide_by_zero = links[DataWidth].div_zero;
   assign rsp_quotient       = links[DataWidth].div_zero ? '0 : links[DataWidth].numq;
   assign rsp_remainder      = links[DataWidth].div_zero ? '0 : links[DataWidth].rem;

`ifndef SYNTHESIS
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_divide_by_zero |-> rsp_remainder < links[DataWidth].den)
      else $error("remainder not below divisor");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> links[1].valid)
      else $error("accepted item missing from first cell");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $countones(valid_vec) == $past($countones(valid_vec)))
      else $error("item count changed during stall");

   a_dz_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_divide_by_zero == (links[DataWidth].den == '0))
      else $error("divide-by-zero flag does not match divisor");
`endif

endmodule

>>> sv/udiv64_cell.sv
// One restoring-division cell: produces one quotient bit per item per stage.
// Depends on udiv64_pkg for stage_type and DataWidth.
module udiv64_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  udiv64_pkg::stage_type stage_in,
   output udiv64_pkg::stage_type stage_out
);
   import udiv64_pkg::*;

   logic [DataWidth:0]   trial;
   logic [DataWidth:0]   diff;
   logic                 ge;
   stage_type            next_in;
   logic                 valid_ff;
   stage_type            data_ff;

   always_comb begin
      trial          = {stage_in.rem, stage_in.numq[DataWidth-1]};
      diff           = trial - {1'b0, stage_in.den};
      ge             = (trial >= {1'b0, stage_in.den});
      next_in        = stage_in;
      next_in.rem    = ge ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
      next_in.numq   = {stage_in.numq[DataWidth-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && stage_in.valid) begin
         data_ff <= next_in;
      end
   end

   always_comb begin
      stage_out       = data_ff;
      stage_out.valid = valid_ff;
   end

endmodule
